// File: src/tsw_pkg.sv
// ----------------------------------------------------------------------------
// Thinning sub-iteration package
// Shared types, geometry constants and the pixel removal rule for the
// Zhang-Suen thinning sub-iteration window unit.
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 4;

    // Column and row counters only ever hold values below the maximum size.
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Register field widths are fixed by the register map.
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [WID_W-1:0] RESET_WIDTH  = WID_W'(1024);
    localparam logic [HGT_W-1:0] RESET_HEIGHT = HGT_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PASS_SELECT  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic drain;
        logic pixel_in;
    } t_in_item;

    typedef struct packed {
        logic pixel_out;
        logic removed;
        logic frame_end;
    } t_out_item;

    // Window bit order: 0..2 top row (NW, N, NE), 3..5 middle row
    // (W, center, E), 6..8 bottom row (SW, S, SE).
    function automatic logic zs_remove(input logic [8:0] win, input logic pass_sel);
        logic [7:0] ring;
        logic [3:0] trans;
        logic [3:0] cnt;
        logic       m1;
        logic       m2;
        ring  = {win[0], win[3], win[6], win[7], win[8], win[5], win[2], win[1]};
        trans = 4'd0;
        cnt   = 4'd0;
        for (int k = 0; k < 8; k++) begin
            trans = trans + 4'(!ring[k] && ring[(k + 1) % 8]);
            cnt   = cnt + 4'(ring[k]);
        end
        if (!pass_sel) begin
            m1 = win[1] & win[5] & win[7];
            m2 = win[5] & win[7] & win[3];
        end else begin
            m1 = win[1] & win[5] & win[3];
            m2 = win[1] & win[7] & win[3];
        end
        return win[4] && (trans == 4'd1) && (cnt >= 4'd2) && (cnt <= 4'd6) && !m1 && !m2;
    endfunction

endpackage

// File: src/thinning_subiteration_window_unit.sv
// ----------------------------------------------------------------------------
// Thinning sub-iteration window unit
// One Zhang-Suen thinning sub-iteration over a raster stream of binary
// pixels, using a two-line column store and a 3x3 window.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_ready   i_in_data   (drain, pixel_in)
//  out       output     o_out_valid / i_out_ready o_out_data  (pixel_out, removed,
//                                                            frame_end)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One item is taken per cycle; the column store read of an accepted item
//  is registered in the window stage, then window and decision go into the
//  output register. The column store has one read and one write port.
//  Reset is synchronous and clears counters and valids; the line store is
//  not cleared. A stalled output holds the window stage, which holds input.
// ----------------------------------------------------------------------------
module thinning_subiteration_window_unit
    import tsw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef struct packed {
        logic             valid;
        logic             pix_item;
        logic             pix;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             border;
        logic             frame_end;
        logic             sel_mid;
    } t_stage;

    // Configuration.
    logic             r_pass;
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;

    // Input-side counters.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_done;
    logic [COL_W-1:0] r_ecol;
    logic [ROW_W-1:0] r_erow;

    // Column store: bit 1 holds the row two above, bit 0 the row above.
    logic [1:0]       r_line [MAX_WIDTH];
    logic [1:0]       r_mem_q;
    logic             r_byp;
    logic [1:0]       r_byp_data;

    t_stage           r_a;
    t_stage           n_a;
    logic [8:0]       r_win;
    logic [8:0]       n_win;
    logic             r_o_valid;
    t_out_item        r_o_data;
    t_out_item        n_o_data;

    logic             cfg_wr;
    logic             in_acc;
    logic             load;
    logic             a_adv;
    logic             a_write;
    logic [WID_W-1:0] w_m1;
    logic [HGT_W-1:0] h_m1;
    logic             col_last;
    logic             row_last;
    logic             ecol_last;
    logic             erow_last;
    logic             pix_emit;
    logic             item_emit;
    logic [COL_W-1:0] rd_addr;
    logic [1:0]       rd_data;
    logic             rem;
    logic [WID_W-1:0] cfg_w;
    logic [HGT_W-1:0] cfg_h;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    assign a_adv      = r_a.valid && (!r_a.emit || !r_o_valid || i_out_ready);
    assign a_write    = a_adv && r_a.pix_item;
    assign o_in_ready = !r_a.valid || a_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    // An early drain leaves no trace, so it never enters the pipeline.
    assign load       = in_acc && (r_done || !i_in_data.drain);

    assign w_m1      = r_width - WID_W'(1);
    assign h_m1      = r_height - HGT_W'(1);
    assign col_last  = ({1'b0, r_col} == w_m1);
    assign row_last  = ({1'b0, r_row} == h_m1);
    assign ecol_last = ({1'b0, r_ecol} == w_m1);
    assign erow_last = ({1'b0, r_erow} == h_m1);
    // A result is due once the pixel one row and one column past it arrives.
    assign pix_emit  = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col != '0));
    assign item_emit = r_done || pix_emit;

    always_comb begin
        if (!r_done) begin
            rd_addr = r_col;
        end else if (erow_last) begin
            rd_addr = r_ecol;
        end else begin
            rd_addr = w_m1[COL_W-1:0];
        end
    end

    always_comb begin
        n_a           = r_a;
        n_a.valid     = 1'b1;
        n_a.pix_item  = !r_done;
        n_a.pix       = i_in_data.pixel_in;
        n_a.col       = r_col;
        n_a.emit      = item_emit;
        n_a.border    = (r_erow == '0) || erow_last || (r_ecol == '0) || ecol_last;
        n_a.frame_end = erow_last && ecol_last;
        n_a.sel_mid   = erow_last;
    end

    // Clamp geometry writes into the supported range.
    always_comb begin
        cfg_w = i_cfg_data[WID_W-1:0];
        if (cfg_w < WID_W'(MIN_SIZE)) begin
            cfg_w = WID_W'(MIN_SIZE);
        end else if (cfg_w > WID_W'(MAX_WIDTH)) begin
            cfg_w = WID_W'(MAX_WIDTH);
        end
        cfg_h = i_cfg_data[HGT_W-1:0];
        if (cfg_h < HGT_W'(MIN_SIZE)) begin
            cfg_h = HGT_W'(MIN_SIZE);
        end else if (cfg_h > HGT_W'(MAX_HEIGHT)) begin
            cfg_h = HGT_W'(MAX_HEIGHT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass   <= 1'b0;
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (cfg_wr) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PASS_SELECT:  r_pass   <= i_cfg_data[0];
                CFG_IMAGE_WIDTH:  r_width  <= cfg_w;
                CFG_IMAGE_HEIGHT: r_height <= cfg_h;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_done <= 1'b0;
            r_ecol <= '0;
            r_erow <= '0;
        end else if (cfg_wr && ((t_cfg_index'(i_cfg_index) == CFG_IMAGE_WIDTH) ||
                                (t_cfg_index'(i_cfg_index) == CFG_IMAGE_HEIGHT))) begin
            r_col  <= '0;
            r_row  <= '0;
            r_done <= 1'b0;
            r_ecol <= '0;
            r_erow <= '0;
        end else if (load) begin
            if (!r_done) begin
                if (col_last) begin
                    r_col <= '0;
                    if (row_last) begin
                        r_row  <= '0;
                        r_done <= 1'b1;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (item_emit) begin
                if (r_done && erow_last && ecol_last) begin
                    // Last result of the frame: start over.
                    r_ecol <= '0;
                    r_erow <= '0;
                    r_done <= 1'b0;
                end else if (ecol_last) begin
                    r_ecol <= '0;
                    r_erow <= r_erow + ROW_W'(1);
                end else begin
                    r_ecol <= r_ecol + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mem_q <= r_line[rd_addr];
        end
        if (a_write) begin
            r_line[r_a.col] <= {rd_data[0], r_a.pix};
        end
    end

    // A read of the column being written in the same cycle takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (load) begin
            r_byp <= a_write && (r_a.col == rd_addr);
        end else if (a_adv) begin
            r_byp <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byp_data <= {rd_data[0], r_a.pix};
        end
    end

    assign rd_data = r_byp ? r_byp_data : r_mem_q;

    always_comb begin
        n_win = ((r_win >> 1) & 9'h0DB) | {r_a.pix, 2'b00, rd_data[0], 2'b00, rd_data[1], 2'b00};
        rem   = r_a.pix_item && !r_a.border && zs_remove(n_win, r_pass);
        n_o_data.removed   = rem;
        n_o_data.frame_end = r_a.frame_end;
        if (r_a.pix_item) begin
            n_o_data.pixel_out = n_win[4] & !rem;
        end else begin
            n_o_data.pixel_out = r_a.sel_mid ? rd_data[0] : rd_data[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_win     <= '0;
        end else begin
            if (load) begin
                r_a <= n_a;
            end else if (a_adv) begin
                r_a.valid <= 1'b0;
            end
            if (a_write) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_adv && r_a.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a.emit) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // Flushed pixels all lie on the frame border.
    a_flush_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a.valid && !r_a.pix_item) |-> r_a.border)
        else $error("flush item not on the border");

    a_removed_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.removed) |-> !o_out_data.pixel_out)
        else $error("removed pixel still set");

    a_done_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ((r_row == '0) && (r_col == '0)))
        else $error("input counters moved after the frame was received");

    a_bypass_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> r_a.valid)
        else $error("bypass set with no item in the window stage");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Thinning sub-iteration window unit testbench
// Streams binary frames through the unit under random idling on both sides,
// predicts every output pixel with an independent model of the sub-iteration
// and checks each result field by field, across both rule sets, clamped and
// extreme frame sizes, drains, abandoned frames and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import tsw_pkg::*;

    localparam int RANDOM_ITEMS  = 520;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT     = 3_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int WIDE_ITEMS    = 40;
    localparam int TALL_ITEMS    = 160;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam logic [15:0]          SQUARE_4X4      = 16'h0660;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    thinning_subiteration_window_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predicted state of the unit.
    bit         upper_store  [MAX_WIDTH];
    bit         middle_store [MAX_WIDTH];
    logic [8:0] nbhd     = '0;
    int         col_at   = 0;
    int         row_at   = 0;
    int         out_at   = 0;
    bit         frame_in = 1'b0;
    bit         rule_set = 1'b0;
    int         cur_w    = int'(RESET_WIDTH);
    int         cur_h    = int'(RESET_HEIGHT);

    t_out_item  expected_pixels [$];

    // Geometry as the stimulus side sees it.
    int         frame_w = int'(RESET_WIDTH);
    int         frame_h = int'(RESET_HEIGHT);

    bit         tx_idle_on      = 1'b1;
    bit         rx_idle_on      = 1'b1;
    int         out_hold_cycles = 0;

    int         errors       = 0;
    int         checked      = 0;
    int         removals     = 0;
    int         frames_done  = 0;
    int         useful_items = 0;

    function automatic int fit_size(int v, int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pick_gap(bit enabled);
        int roll;
        if (!enabled) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic bit remove_center(logic [8:0] w, bit second);
        logic [7:0] ring;
        logic [7:0] next;
        int         ones;
        int         rises;
        bit         blocked;
        // Clockwise from north: N, NE, E, SE, S, SW, W, NW.
        ring[0] = w[1];
        ring[1] = w[2];
        ring[2] = w[5];
        ring[3] = w[8];
        ring[4] = w[7];
        ring[5] = w[6];
        ring[6] = w[3];
        ring[7] = w[0];
        next  = {ring[0], ring[7:1]};
        rises = $countones(~ring & next);
        ones  = $countones(ring);
        if (!second) blocked = ring[2] & ring[4] & (ring[0] | ring[6]);
        else blocked = ring[0] & ring[6] & (ring[2] | ring[4]);
        return w[4] && rises == 1 && ones >= 2 && ones <= 6 && !blocked;
    endfunction

    function automatic void restart_frame();
        col_at   = 0;
        row_at   = 0;
        out_at   = 0;
        frame_in = 1'b0;
    endfunction

    function automatic void queue_result(logic centre, logic [8:0] w);
        t_out_item r;
        int        frame_px;
        int        row;
        int        col;
        bit        thin;
        frame_px = cur_w * cur_h;
        row      = out_at / cur_w;
        col      = out_at % cur_w;
        thin     = 1'b0;
        if (row != 0 && row != cur_h - 1 && col != 0 && col != cur_w - 1)
            thin = remove_center(w, rule_set);
        r.pixel_out = centre & !thin;
        r.removed   = thin;
        r.frame_end = (out_at == frame_px - 1);
        expected_pixels.insert(expected_pixels.size(), r);
        out_at++;
        if (out_at >= frame_px) restart_frame();
    endfunction

    function automatic void thinning_predict(t_in_item it);
        logic above;
        logic level;
        int   pos;
        // Once the whole frame is in, every item pushes out one pending pixel:
        // the tail of the next to last row or a pixel of the bottom row.
        if (frame_in) begin
            if (out_at / cur_w == cur_h - 1) queue_result(middle_store[out_at % cur_w], '0);
            else queue_result(upper_store[cur_w - 1], '0);
            return;
        end
        if (it.drain) return;
        pos   = row_at * cur_w + col_at;
        above = upper_store[col_at];
        level = middle_store[col_at];
        upper_store[col_at]  = level;
        middle_store[col_at] = it.pixel_in;
        nbhd = ((nbhd >> 1) & 9'h0DB) | {it.pixel_in, 2'b00, level, 2'b00, above, 2'b00};
        col_at++;
        if (col_at >= cur_w) begin
            col_at = 0;
            row_at++;
            if (row_at >= cur_h) begin
                row_at   = 0;
                frame_in = 1'b1;
            end
        end
        if (pos >= cur_w + 1) queue_result(nbhd[4], nbhd);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PASS_SELECT: begin
                rule_set = val[0];
            end
            CFG_IMAGE_WIDTH: begin
                cur_w = fit_size(int'(val[WID_W-1:0]), MAX_WIDTH);
                restart_frame();
            end
            CFG_IMAGE_HEIGHT: begin
                cur_h = fit_size(int'(val[HGT_W-1:0]), MAX_HEIGHT);
                restart_frame();
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_pixel(t_out_item got);
        t_out_item want;
        if (expected_pixels.size() == 0) begin
            $error("output item with nothing expected: %b", got);
            errors++;
            return;
        end
        want = expected_pixels.pop_front();
        if (got.pixel_out !== want.pixel_out) begin
            $error("pixel_out mismatch: expected %0b, actual %0b", want.pixel_out, got.pixel_out);
            errors++;
        end
        if (got.removed !== want.removed) begin
            $error("removed mismatch: expected %0b, actual %0b", want.removed, got.removed);
            errors++;
        end
        if (got.frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b", want.frame_end, got.frame_end);
            errors++;
        end
        checked++;
        if (want.removed) removals++;
        if (want.frame_end) frames_done++;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_pixel(o_out_data);
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                if (frame_in || !i_in_data.drain) useful_items++;
                thinning_predict(i_in_data);
            end
        end
    end

    // Output side: random stalls, plus a long hold-off when a test asks.
    initial begin : out_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (out_hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                out_hold_cycles--;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                stall = pick_gap(rx_idle_on);
            end
        end
    end

    task automatic send_item(bit is_drain, bit pix);
        t_in_item it;
        int       gap;
        it.drain    = is_drain;
        it.pixel_in = pix;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        gap = pick_gap(tx_idle_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (last) i_cfg_valid <= 1'b0;
    endtask

    // Upper data bits of the width and pass registers are don't-care.
    task automatic set_frame(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata,
                             bit pass);
        write_reg(CFG_IMAGE_WIDTH, wdata, 1'b0);
        write_reg(CFG_IMAGE_HEIGHT, hdata, 1'b0);
        write_reg(CFG_PASS_SELECT, {12'($urandom), pass}, 1'b1);
        frame_w = fit_size(int'(wdata[WID_W-1:0]), MAX_WIDTH);
        frame_h = fit_size(int'(hdata), MAX_HEIGHT);
    endtask

    task automatic send_pixels(int count, int density, bit noisy);
        for (int p = 0; p < count; p++) begin
            if (noisy && $urandom_range(0, 19) == 0) send_item(1'b1, 1'($urandom));
            send_item(1'b0, $urandom_range(0, 99) < density);
        end
    endtask

    // Some flush items are plain pixels, which the unit treats as drains.
    task automatic flush_frame(bit noisy);
        for (int k = 0; k <= frame_w; k++)
            send_item(!(noisy && $urandom_range(0, 4) == 0), 1'($urandom));
    endtask

    task automatic send_frame(int density, bit noisy);
        send_pixels(frame_w * frame_h, density, noisy);
        flush_frame(noisy);
    endtask

    task automatic test_directed_frame();
        for (int pass = 0; pass < 2; pass++) begin
            wait_drained();
            set_frame(13'd4, 13'd4, 1'(pass));
            send_item(1'b1, 1'b1);
            for (int p = 0; p < 16; p++) send_item(1'b0, SQUARE_4X4[p]);
            send_item(1'b0, 1'b1);
            repeat (4) send_item(1'b1, 1'b0);
            // The frame has wrapped, so this drain finds nothing pending.
            send_item(1'b1, 1'b0);
        end
    endtask

    task automatic test_geometry_restart();
        wait_drained();
        set_frame(13'd6, 13'd5, 1'b0);
        send_pixels(10, 60, 1'b0);
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 13'd6, 1'b1);
        send_pixels(17, 60, 1'b0);
        wait_drained();
        write_reg(CFG_IMAGE_HEIGHT, 13'd5, 1'b1);
        send_frame(60, 1'b0);
    endtask

    task automatic test_size_clamping();
        wait_drained();
        set_frame({2'b11, 11'd0}, 13'd3, 1'b1);
        send_frame(70, 1'b1);
    endtask

    // The widest and tallest frames are only partly sent; the next geometry
    // write cuts them off.
    task automatic test_widest_frame();
        wait_drained();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_frame(13'h1FFF, 13'd4, 1'($urandom));
        send_pixels(WIDE_ITEMS, 50, 1'b0);
    endtask

    task automatic test_tallest_frame();
        wait_drained();
        set_frame(13'd4, 13'h1FFF, 1'($urandom));
        send_pixels(TALL_ITEMS, 50, 1'b0);
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_spare_index();
        wait_drained();
        set_frame(13'd5, 13'd4, 1'b0);
        write_reg(CFG_SPARE_INDEX, 13'($urandom), 1'b1);
        send_frame(55, 1'b1);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        set_frame(13'd8, 13'd6, 1'b1);
        tx_idle_on      = 1'b0;
        out_hold_cycles = HOLD_CYCLES;
        send_frame(50, 1'b0);
        wait_drained();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int start;
        int w;
        int h;
        int runs;
        start = useful_items;
        while (useful_items - start < RANDOM_ITEMS) begin
            wait_drained();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 32) : $urandom_range(4, 10);
            h = $urandom_range(4, 8);
            if ($urandom_range(0, 11) == 0) w = $urandom_range(0, 3);
            if ($urandom_range(0, 11) == 0) h = $urandom_range(0, 3);
            set_frame({2'($urandom), 11'(w)}, 13'(h), 1'($urandom));
            runs = $urandom_range(1, 3);
            for (int f = 0; f < runs; f++) begin
                if (useful_items - start >= RANDOM_ITEMS) break;
                // An abandoned frame is cut off by the next geometry write.
                if ($urandom_range(0, 7) == 0) begin
                    send_pixels($urandom_range(1, frame_w * frame_h - 1),
                                $urandom_range(10, 90), 1'b1);
                    break;
                end
                send_frame($urandom_range(10, 90), 1'b1);
            end
        end
    endtask

    initial begin : main_seq
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frame();
        test_geometry_restart();
        test_size_clamping();
        test_widest_frame();
        test_tallest_frame();
        test_spare_index();
        test_output_backpressure();
        test_random_frames();
        wait_drained();
        $display("Streamed %0d pixel and flush items; %0d output pixels checked.",
                 useful_items, checked);
        $display("Frames completed: %0d, pixels thinned away: %0d, failures: %0d.",
                 frames_done, removals, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
